// ===== rtl/core/modexp_pkg.sv =====
package modexp_pkg;

  localparam int DEFAULT_OPERAND_WIDTH = 63;

  // operation run by the shared modular multiplier
  localparam logic [1:0] OP_REDUCE = 2'd0;  // base mod modulus (a = 1, b = base)
  localparam logic [1:0] OP_SQUARE = 2'd1;  // acc * acc
  localparam logic [1:0] OP_MULT   = 2'd2;  // acc * base

  typedef struct packed {
    logic       load;       // capture a new item
    logic       mul_start;  // clear multiplier accumulator, load b operand
    logic       mul_step;   // one bit of the shift-and-add multiply
    logic [1:0] op;
    logic       wb;         // write multiplier result back
    logic       exp_shift;  // move to the next exponent bit
    logic       out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic exp_msb;  // current exponent bit
  } status_t;

endpackage

// ===== rtl/core/modexp_dp.sv =====
module modexp_dp #(
  parameter int W = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
  input  logic               clk,
  input  modexp_pkg::cmd_t   cmd,
  output modexp_pkg::status_t sts,
  input  logic [W-1:0]       in_base,
  input  logic [W-1:0]       in_exponent,
  input  logic [W-1:0]       in_modulus,
  output logic [W-1:0]       out_power_result
);

  localparam int TW = W + 2;

  logic [W-1:0]  m_r;
  logic [W-1:0]  base_r;
  logic [W-1:0]  exp_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mul_acc_r;
  logic [W-1:0]  mul_b_r;
  logic [W-1:0]  out_r;

  logic [W-1:0]  a_op;
  logic [W-1:0]  b_op;
  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  logic [TW-1:0] red;

  always_comb begin
    case (cmd.op)
      modexp_pkg::OP_REDUCE: begin
        a_op = W'(1);
        b_op = base_r;
      end
      modexp_pkg::OP_SQUARE: begin
        a_op = acc_r;
        b_op = acc_r;
      end
      default: begin
        a_op = base_r;
        b_op = acc_r;
      end
    endcase
  end

  // acc < m and a < m (or a = 1), so 2*acc + a stays below 3m
  always_comb begin
    t  = {1'b0, mul_acc_r, 1'b0} + {2'b00, (mul_b_r[W-1] ? a_op : {W{1'b0}})};
    m1 = {2'b00, m_r};
    m2 = {1'b0, m_r, 1'b0};
    if (t >= m2) begin
      red = t - m2;
    end else if (t >= m1) begin
      red = t - m1;
    end else begin
      red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= in_modulus;
      base_r <= in_base;
      exp_r  <= in_exponent;
      acc_r  <= (in_modulus == W'(1)) ? {W{1'b0}} : W'(1);
    end
    if (cmd.mul_start) begin
      mul_acc_r <= {W{1'b0}};
      mul_b_r   <= b_op;
    end
    if (cmd.mul_step) begin
      mul_acc_r <= red[W-1:0];
      mul_b_r   <= {mul_b_r[W-2:0], 1'b0};
    end
    if (cmd.wb) begin
      if (cmd.op == modexp_pkg::OP_REDUCE) begin
        base_r <= mul_acc_r;
      end else begin
        acc_r <= mul_acc_r;
      end
    end
    if (cmd.exp_shift) begin
      exp_r <= {exp_r[W-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      out_r <= (m_r == {W{1'b0}}) ? {W{1'b0}} : acc_r;
    end
  end

  assign sts.exp_msb      = exp_r[W-1];
  assign out_power_result = out_r;

endmodule

// ===== rtl/core/modexp_ctrl.sv =====
module modexp_ctrl #(
  parameter int W = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  modexp_pkg::status_t sts,
  output modexp_pkg::cmd_t    cmd
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ebit_r, ebit_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    ebit_nxt      = ebit_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.op        = op_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = modexp_pkg::OP_REDUCE;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.mul_start = 1'b1;
        cnt_nxt       = LAST;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_START;
        if (op_r == modexp_pkg::OP_REDUCE) begin
          op_nxt   = modexp_pkg::OP_SQUARE;
          ebit_nxt = LAST;
        end else if (op_r == modexp_pkg::OP_SQUARE && sts.exp_msb) begin
          op_nxt = modexp_pkg::OP_MULT;
        end else begin
          // done with this exponent bit
          cmd.exp_shift = 1'b1;
          op_nxt        = modexp_pkg::OP_SQUARE;
          if (ebit_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            ebit_nxt = ebit_r - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= modexp_pkg::OP_REDUCE;
      cnt_r       <= '0;
      ebit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      ebit_r      <= ebit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// Computes base^exponent mod modulus by left-to-right square-and-multiply. One
// bit-serial modular multiplier (one add plus a reduce by m or 2m per cycle) does
// all the work: first base mod modulus, then for each of the OPERAND_WIDTH exponent
// bits a square and, for a one bit, a multiply by the base. Each multiply runs a
// start step, the shift-and-add steps over the operand bits and a write-back step.
// Items are processed one at a time; the next item is accepted while the previous
// result waits in the output register. Modulus zero returns zero.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OPERAND_WIDTH-1:0] out_power_result
);

  modexp_pkg::cmd_t    cmd;
  modexp_pkg::status_t sts;

  modexp_ctrl #(.W(OPERAND_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  modexp_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_power_result (out_power_result)
  );

endmodule

// ===== rtl/core/modexp_checker.sv =====
module modexp_props #(
  parameter int W = modexp_pkg::DEFAULT_OPERAND_WIDTH
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic [W-1:0] in_base,
  input logic [W-1:0] in_exponent,
  input logic [W-1:0] in_modulus,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_power_result
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // items accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_power_result))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("new item accepted right after another");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result item without a pending input item");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 && !(pend_r == 2'd2 && in_ready))
    else $error("too many items in flight");

endmodule

bind modular_exponentiation modexp_props #(.W(OPERAND_WIDTH)) u_modexp_props (.*);
